// ----- rtl/core/ilb_pkg.sv -----
`default_nettype none

package ilb_pkg;

  // screen coordinates and raster limits
  localparam int SCREEN_BITS = 12;
  localparam int SCREEN_MAX  = 4096;
  localparam int SIZE_BITS   = 13;
  localparam int SCALE_BITS  = 4;
  localparam int COLOR_BITS  = 32;
  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  // defaults for the top-level parameters
  localparam int DEF_FRAME_WIDTH  = 256;
  localparam int DEF_FRAME_HEIGHT = 240;
  localparam int DEF_MAX_FACTOR   = 15;

  // floor(d / s) == (d * recip(s)) >> RECIP_SHIFT for every 12-bit d and s in 1..15
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_BITS  = 17;
  localparam int QUOT_BITS   = SCREEN_BITS + RECIP_BITS;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_SCALE         = 3'd2,
    REG_OFFSET_X      = 3'd3,
    REG_OFFSET_Y      = 3'd4
  } reg_index_t;

  // register values after range limiting
  typedef struct packed {
    logic [SIZE_BITS-1:0]   width;
    logic [SIZE_BITS-1:0]   height;
    logic [SCALE_BITS-1:0]  scale;
    logic [SCREEN_BITS-1:0] off_x;
    logic [SCREEN_BITS-1:0] off_y;
  } cfg_t;

  // one accepted transaction with its screen position resolved
  typedef struct packed {
    logic                   tick;
    logic [SCREEN_BITS-1:0] x;
    logic [SCREEN_BITS-1:0] y;
    logic [COLOR_BITS-1:0]  color;
    logic                   eol;
    logic                   eof;
  } item_t;

  // frame store access prepared by the mapping stages
  typedef struct packed {
    logic                  tick;
    logic                  we;
    logic                  in_area;
    logic                  eol;
    logic                  eof;
    logic [COLOR_BITS-1:0] color;
  } access_t;

  function automatic logic [RECIP_BITS-1:0] recip(input logic [SCALE_BITS-1:0] s);
    logic [RECIP_BITS-1:0] r;
    case (s)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      4'd10:   r = 17'd6554;
      4'd11:   r = 17'd5958;
      4'd12:   r = 17'd5462;
      4'd13:   r = 17'd5042;
      4'd14:   r = 17'd4682;
      4'd15:   r = 17'd4370;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ilb_cfg.sv -----
`default_nettype none

module ilb_cfg #(
  parameter int MAX_FACTOR = ilb_pkg::DEF_MAX_FACTOR
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ilb_pkg::PADDR_W-1:0] paddr,
  input  logic [ilb_pkg::PDATA_W-1:0] pwdata,
  output logic [ilb_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output ilb_pkg::cfg_t               cfg
);
  import ilb_pkg::*;

  logic [SIZE_BITS-1:0]   screen_width;
  logic [SIZE_BITS-1:0]   screen_height;
  logic [SCALE_BITS-1:0]  scale;
  logic [SCREEN_BITS-1:0] offset_x;
  logic [SCREEN_BITS-1:0] offset_y;
  reg_index_t             idx;

  assign pready = 1'b1;
  assign idx    = reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SIZE_BITS'(DEF_FRAME_WIDTH);
      screen_height <= SIZE_BITS'(DEF_FRAME_HEIGHT);
      scale         <= SCALE_BITS'(1);
      offset_x      <= '0;
      offset_y      <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_SCREEN_WIDTH:  screen_width  <= pwdata[SIZE_BITS-1:0];
        REG_SCREEN_HEIGHT: screen_height <= pwdata[SIZE_BITS-1:0];
        REG_SCALE:         scale         <= pwdata[SCALE_BITS-1:0];
        REG_OFFSET_X:      offset_x      <= pwdata[SCREEN_BITS-1:0];
        REG_OFFSET_Y:      offset_y      <= pwdata[SCREEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SCREEN_WIDTH:  prdata = PDATA_W'(screen_width);
      REG_SCREEN_HEIGHT: prdata = PDATA_W'(screen_height);
      REG_SCALE:         prdata = PDATA_W'(scale);
      REG_OFFSET_X:      prdata = PDATA_W'(offset_x);
      REG_OFFSET_Y:      prdata = PDATA_W'(offset_y);
      default:           prdata = '0;
    endcase
  end

  // range limiting
  always_comb begin
    if (screen_width == '0)                          cfg.width = SIZE_BITS'(1);
    else if (screen_width > SIZE_BITS'(SCREEN_MAX))  cfg.width = SIZE_BITS'(SCREEN_MAX);
    else                                             cfg.width = screen_width;
    if (screen_height == '0)                         cfg.height = SIZE_BITS'(1);
    else if (screen_height > SIZE_BITS'(SCREEN_MAX)) cfg.height = SIZE_BITS'(SCREEN_MAX);
    else                                             cfg.height = screen_height;
    if (scale == '0)                                 cfg.scale = SCALE_BITS'(1);
    else if (scale > SCALE_BITS'(MAX_FACTOR))        cfg.scale = SCALE_BITS'(MAX_FACTOR);
    else                                             cfg.scale = scale;
    cfg.off_x = offset_x;
    cfg.off_y = offset_y;
  end

endmodule

`default_nettype wire

// ----- rtl/core/ilb_raster.sv -----
`default_nettype none

module ilb_raster (
  input  logic                           clk,
  input  logic                           rst,
  input  ilb_pkg::cfg_t                  cfg,
  input  logic                           take,
  input  logic                           kind,
  input  logic [7:0]                     pos_x,
  input  logic [7:0]                     pos_y,
  input  logic [ilb_pkg::COLOR_BITS-1:0] color,
  input  logic                           down_ready,
  output logic                           ready,
  output logic                           valid,
  output ilb_pkg::item_t                 item
);
  import ilb_pkg::*;

  logic [SCREEN_BITS-1:0] screen_col;
  logic [SCREEN_BITS-1:0] screen_row;
  logic [SCREEN_BITS-1:0] screen_col_next;
  logic [SCREEN_BITS-1:0] screen_row_next;
  logic                   eol;
  logic                   last_row;

  assign ready = !valid || down_ready;

  always_comb begin
    eol      = ({1'b0, screen_col} + SIZE_BITS'(1)) >= cfg.width;
    last_row = ({1'b0, screen_row} + SIZE_BITS'(1)) >= cfg.height;
    if (eol) begin
      screen_col_next = '0;
      screen_row_next = last_row ? '0 : screen_row + SCREEN_BITS'(1);
    end else begin
      screen_col_next = screen_col + SCREEN_BITS'(1);
      screen_row_next = screen_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      screen_col <= '0;
      screen_row <= '0;
    end else if (take) begin
      valid <= 1'b1;
      if (kind == KIND_TICK) begin
        screen_col <= screen_col_next;
        screen_row <= screen_row_next;
      end
    end else if (down_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.tick  <= (kind == KIND_TICK);
      item.x     <= (kind == KIND_TICK) ? screen_col : SCREEN_BITS'(pos_x);
      item.y     <= (kind == KIND_TICK) ? screen_row : SCREEN_BITS'(pos_y);
      item.color <= color;
      item.eol   <= (kind == KIND_TICK) && eol;
      item.eof   <= (kind == KIND_TICK) && eol && last_row;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ilb_map.sv -----
`default_nettype none

module ilb_map #(
  parameter int FRAME_WIDTH  = ilb_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = ilb_pkg::DEF_FRAME_HEIGHT,
  parameter int MAX_FACTOR   = ilb_pkg::DEF_MAX_FACTOR,
  localparam int AW = $clog2(FRAME_WIDTH * FRAME_HEIGHT)
) (
  input  logic              clk,
  input  logic              rst,
  input  ilb_pkg::cfg_t     cfg,
  input  logic              up_valid,
  input  ilb_pkg::item_t    item,
  output logic              ready,
  input  logic              down_ready,
  output logic              valid,
  output ilb_pkg::access_t  acc,
  output logic [AW-1:0]     addr
);
  import ilb_pkg::*;

  localparam int XW   = $clog2(FRAME_WIDTH);
  localparam int YW   = $clog2(FRAME_HEIGHT);
  localparam int LIMW = $clog2(FRAME_WIDTH * MAX_FACTOR + 1);
  localparam int CW   = (LIMW > SCREEN_BITS) ? LIMW : SCREEN_BITS;

  // offset removal, rectangle test and reciprocal multiply
  logic                   v2;
  logic                   tick2;
  logic                   in_area2;
  logic                   wok2;
  logic                   eol2;
  logic                   eof2;
  logic [QUOT_BITS-1:0]   qmx2;
  logic [QUOT_BITS-1:0]   qmy2;
  logic [SCREEN_BITS-1:0] x2;
  logic [SCREEN_BITS-1:0] y2;
  logic [COLOR_BITS-1:0]  color2;
  logic                   ready2;
  logic                   ready3;

  logic [SCREEN_BITS-1:0] dx;
  logic [SCREEN_BITS-1:0] dy;
  logic [CW-1:0]          lim_x;
  logic [CW-1:0]          lim_y;
  logic [RECIP_BITS-1:0]  r;
  logic                   in_area;
  logic                   wok;

  always_comb begin
    dx      = item.x - cfg.off_x;
    dy      = item.y - cfg.off_y;
    lim_x   = CW'(FRAME_WIDTH) * CW'(cfg.scale);
    lim_y   = CW'(FRAME_HEIGHT) * CW'(cfg.scale);
    r       = recip(cfg.scale);
    in_area = (item.x >= cfg.off_x) && (item.y >= cfg.off_y) &&
              (CW'(dx) < lim_x) && (CW'(dy) < lim_y);
    wok     = (item.x < SCREEN_BITS'(FRAME_WIDTH)) && (item.y < SCREEN_BITS'(FRAME_HEIGHT));
  end

  // upstream sees the first stage's ready
  assign ready3 = !valid || down_ready;
  assign ready2 = !v2 || ready3;
  assign ready  = ready2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && up_valid) begin
      tick2    <= item.tick;
      in_area2 <= in_area;
      wok2     <= wok;
      eol2     <= item.eol;
      eof2     <= item.eof;
      qmx2     <= QUOT_BITS'(dx) * QUOT_BITS'(r);
      qmy2     <= QUOT_BITS'(dy) * QUOT_BITS'(r);
      x2       <= item.x;
      y2       <= item.y;
      color2   <= item.color;
    end
  end

  // store address; outside the game area the read goes to entry zero
  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic [AW-1:0] addr_next;

  always_comb begin
    if (tick2) begin
      col = in_area2 ? qmx2[RECIP_SHIFT +: XW] : '0;
      row = in_area2 ? qmy2[RECIP_SHIFT +: YW] : '0;
    end else begin
      col = x2[XW-1:0];
      row = y2[YW-1:0];
    end
    addr_next = AW'(row) * AW'(FRAME_WIDTH) + AW'(col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready3) begin
      valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && v2) begin
      acc.tick    <= tick2;
      acc.we      <= !tick2 && wok2;
      acc.in_area <= in_area2;
      acc.eol     <= eol2;
      acc.eof     <= eof2;
      acc.color   <= color2;
      addr        <= addr_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ilb_store.sv -----
`default_nettype none

module ilb_store #(
  parameter int FRAME_WIDTH  = ilb_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = ilb_pkg::DEF_FRAME_HEIGHT,
  localparam int AW = $clog2(FRAME_WIDTH * FRAME_HEIGHT)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           up_valid,
  input  ilb_pkg::access_t               acc,
  input  logic [AW-1:0]                  addr,
  output logic                           ready,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [ilb_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                           end_of_line,
  output logic                           end_of_frame,
  output logic                           clearing
);
  import ilb_pkg::*;

  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;

  logic [COLOR_BITS-1:0] mem [DEPTH];
  logic [COLOR_BITS-1:0] rdata;
  logic [AW-1:0]         clr_cnt;
  logic                  in_area;
  logic                  go;

  assign ready = !out_valid || !out_stall;
  assign go    = up_valid && ready;

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt] <= '0;
    end else if (go && acc.we) begin
      mem[addr] <= acc.color;
    end
    if (go && acc.tick) begin
      rdata <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + AW'(1);
        if (clr_cnt == AW'(DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (ready) begin
        out_valid <= up_valid && acc.tick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && acc.tick) begin
      in_area      <= acc.in_area;
      end_of_line  <= acc.eol;
      end_of_frame <= acc.eof;
    end
  end

  assign pixel_color = in_area ? rdata : '0;

endmodule

`default_nettype wire

// ----- rtl/core/integer_upscale_letterbox.sv -----
`default_nettype none

// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+------------------------------------
// input     | in        | in_valid / in_stall   | kind, pos_x, pos_y, color
// output    | out       | out_valid / out_stall | pixel_color, end_of_line, end_of_frame
// config    | in        | apb psel/penable      | paddr, pwdata, prdata, pready
//
// one transaction per cycle sustained while out_stall is low; ticks pass raster, map, store
// after reset a clearing pass zeroes all FRAME_WIDTH*FRAME_HEIGHT entries of the frame
// store (61440 at the defaults), one entry per cycle; in_stall stays high meanwhile
// every stage holds its own valid, so a stalled output only backs up the stages behind it
// rst is synchronous, active high; the frame store itself has no reset
module integer_upscale_letterbox #(
  parameter int FRAME_WIDTH  = ilb_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = ilb_pkg::DEF_FRAME_HEIGHT,
  parameter int MAX_FACTOR   = ilb_pkg::DEF_MAX_FACTOR
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           kind,
  input  logic [7:0]                     pos_x,
  input  logic [7:0]                     pos_y,
  input  logic [ilb_pkg::COLOR_BITS-1:0] color,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ilb_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                           end_of_line,
  output logic                           end_of_frame,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ilb_pkg::PADDR_W-1:0]    paddr,
  input  logic [ilb_pkg::PDATA_W-1:0]    pwdata,
  output logic [ilb_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import ilb_pkg::*;

  localparam int AW = $clog2(FRAME_WIDTH * FRAME_HEIGHT);

  cfg_t          cfg;
  item_t         item;
  access_t       acc;
  logic [AW-1:0] addr;
  logic          take;
  logic          raster_ready;
  logic          raster_valid;
  logic          map_ready;
  logic          map_valid;
  logic          store_ready;
  logic          clearing;

  // registers sit behind the apb port; the user must change them only while idle, the block does not enforce it
  ilb_cfg #(
    .MAX_FACTOR (MAX_FACTOR)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input acceptance is blocked during the clearing pass
  assign in_stall = !raster_ready || clearing;
  assign take     = in_valid && !in_stall;

  // input register; ticks pick up and advance the screen position here
  ilb_raster u_raster (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .take       (take),
    .kind       (kind),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .color      (color),
    .down_ready (map_ready),
    .ready      (raster_ready),
    .valid      (raster_valid),
    .item       (item)
  );

  // screen position to frame coordinate: offset, rectangle test, divide by scale
  ilb_map #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .MAX_FACTOR   (MAX_FACTOR)
  ) u_map (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .up_valid   (raster_valid),
    .item       (item),
    .ready      (map_ready),
    .down_ready (store_ready),
    .valid      (map_valid),
    .acc        (acc),
    .addr       (addr)
  );

  // frame store; writes and reads reach it in arrival order, so a tick
  // always sees every in-frame write accepted before it
  ilb_store #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_store (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (map_valid),
    .acc          (acc),
    .addr         (addr),
    .ready        (store_ready),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .pixel_color  (pixel_color),
    .end_of_line  (end_of_line),
    .end_of_frame (end_of_frame),
    .clearing     (clearing)
  );

  // the last pixel of a frame is also the last of its line
  a_eof_on_eol : assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_frame) |-> end_of_line)
    else $error("end_of_frame without end_of_line");

  // nothing is in flight while the clearing pass owns the store write port
  a_clear_empty : assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!raster_valid && !map_valid && !out_valid))
    else $error("transaction in flight during clearing pass");

  // an accepted transaction shows up in the input register on the next edge
  a_take_lands : assert property (@(posedge clk) disable iff (rst)
    take |=> raster_valid)
    else $error("accepted transaction lost at input register");

endmodule

`default_nettype wire
